// ===== hdl/hrds_pkg.sv =====
// shared types and the hex digit decoder for the hex record data summer
`default_nettype none
package hrds_pkg;

  // line layout of a hex record
  localparam int unsigned PosW      = 10;
  localparam logic [PosW-1:0] PosMax    = 10'd1023;
  localparam logic [PosW-1:0] DataStart = 10'd9;
  localparam logic [7:0] CharNewline    = 8'd10;
  localparam logic [7:0] TypeData       = 8'h00;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } item_t;

  // what the line decoder knows about the line that is about to close
  typedef struct packed {
    logic        empty;     // no character seen on this line
    logic        bad;       // bad digit or fewer than nine characters
    logic        data;      // clean type-00 record
    logic [7:0]  length;
    logic [15:0] byte_sum;
  } line_info_t;

  // decoded hex digit: valid flag and nibble value
  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.valid = 1'b1;
    r.nib   = 4'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      r.nib = 4'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd70) begin
      r.nib = 4'(c - 8'd55);
    end else if (c >= 8'd97 && c <= 8'd102) begin
      r.nib = 4'(c - 8'd87);
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/hrds_in_reg.sv =====
// input register of the hex record data summer
`default_nettype none
module hrds_in_reg (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire hrds_pkg::item_t in_item_i,
  input  wire                 step_i,     // held word is consumed this cycle
  output logic                valid_o,
  output hrds_pkg::item_t     item_o
);
  import hrds_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // stall only while a held word cannot move on
  assign in_stall_o = valid_q && !step_i;

  always_comb begin
    valid_d = valid_q;
    if (!in_stall_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule
`default_nettype wire

// ===== hdl/hrds_line_dec.sv =====
// per-line field decoder of the hex record data summer
`default_nettype none
module hrds_line_dec (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   take_i,    // non-closing character
  input  wire                   close_i,   // newline or end of text
  input  wire [7:0]             char_code_i,
  output hrds_pkg::line_info_t  info_o
);
  import hrds_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      type_q, type_d;
  logic [3:0]      high_q, high_d;
  logic            bad_q, bad_d;
  logic [15:0]     sum_q, sum_d;
  logic [PosW-1:0] data_end;
  hex_digit_t      dig;

  assign dig      = hex_decode(char_code_i);
  assign data_end = DataStart + {1'b0, len_q, 1'b0};

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    type_d = type_q;
    high_d = high_q;
    bad_d  = bad_q;
    sum_d  = sum_q;
    if (close_i) begin
      pos_d  = '0;
      len_d  = '0;
      type_d = '0;
      high_d = '0;
      bad_d  = 1'b0;
      sum_d  = '0;
    end else if (take_i) begin
      if (pos_q >= 10'd1 && pos_q <= 10'd8) begin
        if (!dig.valid) bad_d = 1'b1;
        if (pos_q == 10'd1 || pos_q == 10'd2) begin
          len_d = {len_q[3:0], dig.nib};
        end else if (pos_q == 10'd7 || pos_q == 10'd8) begin
          type_d = {type_q[3:0], dig.nib};
        end
      end else if (pos_q >= DataStart && pos_q < data_end) begin
        if (!dig.valid) bad_d = 1'b1;
        // odd position opens a byte, even position completes it
        if (pos_q[0]) begin
          high_d = dig.nib;
        end else begin
          sum_d = sum_q + {8'd0, high_q, dig.nib};
        end
      end
      pos_d = (pos_q < PosMax) ? pos_q + 10'd1 : PosMax;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
      high_q <= '0;
      bad_q  <= 1'b0;
      sum_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      type_q <= type_d;
      high_q <= high_d;
      bad_q  <= bad_d;
      sum_q  <= sum_d;
    end
  end

  always_comb begin
    info_o.empty    = (pos_q == '0);
    info_o.bad      = (pos_q < DataStart) || bad_q;
    info_o.data     = !info_o.bad && (type_q == TypeData);
    info_o.length   = len_q;
    info_o.byte_sum = sum_q;
  end

endmodule
`default_nettype wire

// ===== hdl/hrds_totals.sv =====
// running totals and result register of the hex record data summer
`default_nettype none
module hrds_totals (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       close_i,
  input  wire                       eot_i,
  input  wire hrds_pkg::line_info_t info_i,
  input  wire                       out_stall_i,
  output logic                      out_valid_o,
  output logic                      out_free_o,
  output logic [31:0]               size_o,
  output logic [31:0]               sum_o,
  output logic [7:0]                last_len_o,
  output logic                      was_data_o,
  output logic                      bad_o,
  output logic                      done_o
);
  import hrds_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] size_q, size_d;
  logic [31:0] sum_q, sum_d;
  logic [7:0]  last_q, last_d;
  logic        was_data, bad;
  logic        was_data_q, bad_q, done_q;

  assign out_free_o = !valid_q || !out_stall_i;

  // empty end of text is neither data nor bad
  assign bad      = !(eot_i && info_i.empty) && info_i.bad;
  assign was_data = !(eot_i && info_i.empty) && info_i.data;

  always_comb begin
    size_d  = size_q;
    sum_d   = sum_q;
    last_d  = last_q;
    valid_d = valid_q && out_stall_i;
    if (close_i) begin
      valid_d = 1'b1;
      if (was_data) begin
        size_d = size_q + {24'd0, info_i.length};
        sum_d  = sum_q + {16'd0, info_i.byte_sum};
        last_d = info_i.length;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      size_q  <= '0;
      sum_q   <= '0;
      last_q  <= '0;
    end else begin
      valid_q <= valid_d;
      size_q  <= size_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_i) begin
      was_data_q <= was_data;
      bad_q      <= bad;
      done_q     <= eot_i;
    end
  end

  assign out_valid_o = valid_q;
  assign size_o      = size_q;
  assign sum_o       = sum_q;
  assign last_len_o  = last_q;
  assign was_data_o  = was_data_q;
  assign bad_o       = bad_q;
  assign done_o      = done_q;

endmodule
`default_nettype wire

// ===== hdl/hex_record_data_summer_core.sv =====
// top level of the hex record data summer
// takes hex record text one character word per cycle, unless stalled, and reports
// running totals of type-00 records at every line close. a word passes an
// input register, then the line decoder and accumulators, into the result
// register. the only thing that slows intake is a closing word waiting
// while the result register is stalled; intake stops until it moves on.
// the record checksum is not checked, and totals clear only on reset
`default_nettype none
module hex_record_data_summer_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  in_char_code_i,
  input  wire         in_end_of_text_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] out_data_size_total_o,
  output logic [31:0] out_byte_sum_total_o,
  output logic [7:0]  out_last_data_length_o,
  output logic        out_record_was_data_o,
  output logic        out_record_bad_o,
  output logic        out_text_done_o
);
  import hrds_pkg::*;

  item_t      in_item, held_item;
  logic       held_valid;
  logic       out_free;
  logic       is_close;
  logic       step, close, take;
  line_info_t info;

  assign in_item.char_code   = in_char_code_i;
  assign in_item.end_of_text = in_end_of_text_i;

  // a closing word needs room in the result register, any other word moves on
  assign is_close = held_item.end_of_text || held_item.char_code == CharNewline;
  assign step     = held_valid && (out_free || !is_close);
  assign close    = step && is_close;
  assign take     = step && !close;

  hrds_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .step_i     (step),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  hrds_line_dec u_line_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .close_i     (close),
    .char_code_i (held_item.char_code),
    .info_o      (info)
  );

  hrds_totals u_totals (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .close_i     (close),
    .eot_i       (held_item.end_of_text),
    .info_i      (info),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_free_o  (out_free),
    .size_o      (out_data_size_total_o),
    .sum_o       (out_byte_sum_total_o),
    .last_len_o  (out_last_data_length_o),
    .was_data_o  (out_record_was_data_o),
    .bad_o       (out_record_bad_o),
    .done_o      (out_text_done_o)
  );

`ifndef SYNTHESIS
  // a result word is never both a counted record and a bad line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_record_was_data_o && out_record_bad_o))
    else $error("result marked both data and bad");

  // intake stalls only while a word is held in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> held_valid)
    else $error("stall with empty input register");

  // totals move only on a line close
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !close |=> $stable(out_data_size_total_o) && $stable(out_byte_sum_total_o))
    else $error("totals changed without a line close");

  // a close always leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |=> out_valid_o)
    else $error("line close produced no result");
`endif

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// self-checking bench for the hex record data summer core
module testbench;
  import hrds_pkg::*;

  localparam int CycleLimit = 150000;
  localparam int PhaseWords = 220;
  localparam int HoldCycles = 300;
  localparam int PrintCap   = 40;

  // kinds of generated record lines
  typedef enum int {LINE_CLEAN, LINE_CUT, LINE_BAD} line_kind_e;

  // one set of running totals as the block reports them
  typedef struct packed {
    logic [31:0] size_total;
    logic [31:0] byte_total;
    logic [7:0]  last_len;
    logic        was_data;
    logic        bad;
    logic        done;
  } totals_t;

  // dut ports, inputs known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_char_code_i = 8'd0;
  logic        in_end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_data_size_total_o;
  logic [31:0] out_byte_sum_total_o;
  logic [7:0]  out_last_data_length_o;
  logic        out_record_was_data_o;
  logic        out_record_bad_o;
  logic        out_text_done_o;

  // pending words, expected totals and the line being assembled
  item_t       word_q[$];
  totals_t     totals_q[$];
  logic [7:0]  line_buf[$];

  // pacing controls, owned by the stimulus process
  int          send_idle_pct = 31;
  int          recv_idle_pct = 63;
  logic        hold_req = 1'b0;

  logic        word_taken = 1'b0;
  int          words_queued = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          n_results = 0;
  int          n_data = 0;
  int          n_rejected = 0;
  int          n_text_end = 0;

  // predictor state of the current line and the totals
  logic [9:0]  line_pos = '0;
  logic [7:0]  line_len = '0;
  logic [7:0]  line_type = '0;
  logic [3:0]  high_nib = '0;
  logic        line_bad = 1'b0;
  logic [15:0] line_sum = '0;
  logic [31:0] size_acc = '0;
  logic [31:0] sum_acc = '0;
  logic [7:0]  last_len = '0;

  hex_record_data_summer_core dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_char_code_i         (in_char_code_i),
    .in_end_of_text_i       (in_end_of_text_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_data_size_total_o  (out_data_size_total_o),
    .out_byte_sum_total_o   (out_byte_sum_total_o),
    .out_last_data_length_o (out_last_data_length_o),
    .out_record_was_data_o  (out_record_was_data_o),
    .out_record_bad_o       (out_record_bad_o),
    .out_text_done_o        (out_text_done_o)
  );

  always #1 clk_i = ~clk_i;

  // {ok, nibble} of one text character
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    return 5'b0;
  endfunction

  // advance the line state by one accepted word, queue totals on a close
  task automatic absorb_word(input logic [7:0] code, input logic eot);
    totals_t t;
    logic [4:0] d;
    int data_end;
    if (!eot && code != CharNewline) begin
      d = digit_value(code);
      data_end = int'(DataStart) + 2 * int'(line_len);
      if (line_pos >= 1 && line_pos <= 8) begin
        // length, address and type digits are all checked
        if (!d[4]) line_bad = 1'b1;
        if (line_pos <= 2) line_len = {line_len[3:0], d[3:0]};
        else if (line_pos >= 7) line_type = {line_type[3:0], d[3:0]};
      end else if (line_pos >= DataStart && int'(line_pos) < data_end) begin
        if (!d[4]) line_bad = 1'b1;
        // data pairs start on odd positions
        if (line_pos[0]) high_nib = d[3:0];
        else line_sum = line_sum + {high_nib, d[3:0]};
      end
      if (line_pos != PosMax) line_pos = line_pos + 1'b1;
    end else begin
      t = '0;
      t.done = eot;
      // an end of text on an empty line reports totals only
      if (!(eot && line_pos == 0)) begin
        if (line_pos < DataStart || line_bad) begin
          t.bad = 1'b1;
        end else if (line_type == TypeData) begin
          t.was_data = 1'b1;
          size_acc = size_acc + line_len;
          sum_acc = sum_acc + line_sum;
          last_len = line_len;
        end
      end
      t.size_total = size_acc;
      t.byte_total = sum_acc;
      t.last_len = last_len;
      totals_q.push_back(t);
      line_pos = '0;
      line_len = '0;
      line_type = '0;
      high_nib = '0;
      line_bad = 1'b0;
      line_sum = '0;
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatch_count < PrintCap)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_totals();
    totals_t want;
    if (totals_q.size() == 0) begin
      flag_mismatch("result word with nothing expected", out_data_size_total_o, 32'd0);
    end else begin
      want = totals_q.pop_front();
      n_results++;
      if (want.was_data) n_data++;
      if (want.bad) n_rejected++;
      if (want.done) n_text_end++;
      if (out_data_size_total_o !== want.size_total)
        flag_mismatch("data_size_total", out_data_size_total_o, want.size_total);
      if (out_byte_sum_total_o !== want.byte_total)
        flag_mismatch("byte_sum_total", out_byte_sum_total_o, want.byte_total);
      if (out_last_data_length_o !== want.last_len)
        flag_mismatch("last_data_length", 32'(out_last_data_length_o), 32'(want.last_len));
      if (out_record_was_data_o !== want.was_data)
        flag_mismatch("record_was_data", 32'(out_record_was_data_o), 32'(want.was_data));
      if (out_record_bad_o !== want.bad)
        flag_mismatch("record_bad", 32'(out_record_bad_o), 32'(want.bad));
      if (out_text_done_o !== want.done)
        flag_mismatch("text_done", 32'(out_text_done_o), 32'(want.done));
    end
  endtask

  // monitor: results are checked before the same edge's input is predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_totals();
      if (in_valid_i && !in_stall_o) absorb_word(in_char_code_i, in_end_of_text_i);
    end
    word_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  // driver: a stalled word holds, otherwise the next one may follow
  always @(negedge clk_i) begin
    item_t w;
    if (rst_ni && (!in_valid_i || word_taken)) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = word_q.pop_front();
        in_valid_i <= 1'b1;
        in_char_code_i <= w.char_code;
        in_end_of_text_i <= w.end_of_text;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold each time hold_req flips
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[hex_record_data_summer_core] ERROR");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] code, input logic eot);
    item_t w;
    w.char_code = code;
    w.end_of_text = eot;
    word_q.push_back(w);
    words_queued++;
  endtask

  // hex digit in random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (digit_value(c) != 0 || c == CharNewline);
    return c;
  endfunction

  task automatic put_hex(input logic [7:0] b);
    line_buf.push_back(hex_char(b[7:4]));
    line_buf.push_back(hex_char(b[3:0]));
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // move the assembled line to the word queue and close it
  task automatic flush_line(input logic by_eot);
    foreach (line_buf[i]) push_word(line_buf[i], 1'b0);
    if (by_eot) push_word(8'($urandom_range(255)), 1'b1);
    else push_word(CharNewline, 1'b0);
    line_buf.delete();
  endtask

  // one record line, optionally cut short, corrupted or padded with junk
  task automatic build_record(input logic [7:0] len, input logic [7:0] rtype,
                              input line_kind_e kind, input logic by_eot,
                              input int tail);
    int keep;
    int spot;
    int data_end;
    logic [7:0] c;
    line_buf.delete();
    // start code is not examined, so it is sometimes junk
    line_buf.push_back($urandom_range(19) == 0 ? non_hex_char() : 8'h3A);
    put_hex(len);
    put_hex(8'($urandom_range(255)));
    put_hex(8'($urandom_range(255)));
    put_hex(rtype);
    repeat (len) put_hex(8'($urandom_range(255)));
    if ($urandom_range(1)) put_hex(8'($urandom_range(255)));
    if ($urandom_range(3) == 0) line_buf.push_back(8'h0D);
    repeat (tail) begin
      c = 8'($urandom_range(255));
      line_buf.push_back(c == CharNewline ? 8'h20 : c);
    end
    data_end = int'(DataStart) + 2 * int'(len);
    case (kind)
      LINE_CUT: begin
        // zero length cuts into the header, otherwise into the data
        keep = (len == 0) ? $urandom_range(1, 8) : $urandom_range(9, data_end - 1);
        while (line_buf.size() > keep) void'(line_buf.pop_back());
      end
      LINE_BAD: begin
        spot = $urandom_range(1, data_end - 1);
        line_buf[spot] = non_hex_char();
      end
      default: ;
    endcase
    flush_line(by_eot);
  endtask

  function automatic logic [7:0] pick_length();
    int p;
    p = $urandom_range(99);
    if (p < 70) return 8'($urandom_range(16));
    if (p < 95) return 8'($urandom_range(17, 40));
    return 8'($urandom_range(200, 255));
  endfunction

  function automatic logic [7:0] pick_type();
    int p;
    p = $urandom_range(99);
    if (p < 75) return TypeData;
    if (p < 90) return 8'($urandom_range(1, 5));
    return 8'($urandom_range(255));
  endfunction

  // mostly well-formed records, the rest broken lines and noise
  task automatic queue_random_text(input int goal);
    int start;
    int r;
    start = words_queued;
    while (words_queued - start < goal) begin
      r = $urandom_range(99);
      if (r < 60) begin
        build_record(pick_length(), pick_type(), LINE_CLEAN, $urandom_range(9) == 0, 0);
      end else if (r < 70) begin
        build_record(pick_length(), pick_type(), LINE_CUT, $urandom_range(9) == 0, 0);
      end else if (r < 80) begin
        build_record(pick_length(), pick_type(), LINE_BAD, $urandom_range(9) == 0, 0);
      end else if (r < 88) begin
        // short line: fewer than nine characters
        line_buf.push_back(8'h3A);
        repeat ($urandom_range(7)) line_buf.push_back(hex_char(4'($urandom_range(15))));
        flush_line($urandom_range(3) == 0);
      end else if (r < 95) begin
        // raw noise, a stray newline included now and then
        repeat ($urandom_range(1, 12)) push_word(8'($urandom_range(255)), 1'b0);
        push_word(CharNewline, 1'b0);
      end else begin
        push_word(8'($urandom_range(255)), 1'b1);
      end
    end
  endtask

  // wait until the bench has nothing in flight, then let the pipe settle
  task automatic wait_drained();
    while (word_q.size() != 0 || in_valid_i || totals_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed lines
    push_word(8'hFF, 1'b1);                   // end of text on an empty line
    flush_line(1'b0);                         // empty line closed by newline
    put_text(":0"); flush_line(1'b0);         // short line
    put_text(":01000000ff"); flush_line(1'b1); // data record closed by end of text
    put_text(":0100G000"); flush_line(1'b0);  // bad digit in the address
    put_text(":00000001"); flush_line(1'b0);  // end-of-file type, not counted
    put_text(":FF00000000"); flush_line(1'b0); // longest length, truncated data
    put_text(":02000000aB7"); flush_line(1'b0); // lone trailing digit dropped

    // sender idles less than receiver
    send_idle_pct = 31;
    recv_idle_pct = 63;
    queue_random_text(PhaseWords);
    wait_drained();

    // the other way round
    send_idle_pct = 63;
    recv_idle_pct = 31;
    queue_random_text(PhaseWords);
    wait_drained();

    // full rate with one long output hold while words keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_text(PhaseWords);
    hold_req = ~hold_req;
    // full-length record with junk past the data field
    build_record(8'hFF, TypeData, LINE_CLEAN, 1'b0, 40);
    push_word(8'h00, 1'b1);
    wait_drained();

    $display("checked %0d result words from %0d input words: %0d data records,",
             n_results, words_queued, n_data);
    $display("%0d rejected lines, %0d text ends over three pacing phases and a long hold",
             n_rejected, n_text_end);
    if (mismatch_count == 0) begin
      $display("[hex_record_data_summer_core] OK");
    end else begin
      $display("[hex_record_data_summer_core] ERROR");
    end
    $finish;
  end

endmodule
